@@ src/deq_pkg.sv @@
// Shared types and codes for the double-ended queue block.
package deq_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 16;
  localparam int REQ_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int ITEM_COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

  // Operation seen by every cell of a row; index 0 of a row is its anchor end.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_ANCHOR,
    CELL_PUSH_OPEN,
    CELL_POP_ANCHOR,
    CELL_POP_OPEN
  } cell_op_t;

  typedef struct packed {
    logic        [REQ_W-1:0]  req_type;
    logic signed [DATA_W-1:0] push_value;
  } deq_req_t;

  typedef struct packed {
    logic        [STATUS_W-1:0]     status;
    logic signed [DATA_W-1:0]       popped_value;
    logic signed [DATA_W-1:0]       front_value;
    logic signed [DATA_W-1:0]       back_value;
    logic        [ITEM_COUNT_W-1:0] item_count;
    logic                           is_empty;
  } deq_rsp_t;

endpackage

@@ src/deq_cell.sv @@
// One storage cell of a row: a value and its valid bit, updated from its neighbors.
module deq_cell import deq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_op_t                 op,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic                     inner_valid,
  input  logic signed [DATA_W-1:0] inner_data,
  input  logic                     outer_valid,
  input  logic signed [DATA_W-1:0] outer_data,
  output logic                     valid_q,
  output logic signed [DATA_W-1:0] data_q
);

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    unique case (op)
      CELL_PUSH_ANCHOR: begin
        // shift away from the anchor; the anchor cell takes the new item
        valid_nxt = inner_valid;
        data_nxt  = inner_data;
      end
      CELL_PUSH_OPEN: begin
        // first free cell past the occupied run takes the item
        if (!valid_r && inner_valid) begin
          valid_nxt = 1'b1;
          data_nxt  = push_value;
        end
      end
      CELL_POP_ANCHOR: begin
        valid_nxt = outer_valid;
        data_nxt  = outer_data;
      end
      CELL_POP_OPEN: begin
        // drop the last occupied cell
        if (valid_r && !outer_valid) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
        valid_nxt = valid_r;
        data_nxt  = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_q = valid_r;
  assign data_q  = data_r;

endmodule

@@ src/deq_row.sv @@
// Row of cells kept packed against index 0, the anchor end.
module deq_row import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_op_t                 op,
  input  logic signed [DATA_W-1:0] push_value,
  output logic signed [DATA_W-1:0] anchor_data
);

  logic                     valid_w [DEPTH];
  logic signed [DATA_W-1:0] data_w  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     in_valid;
    logic signed [DATA_W-1:0] in_data;
    logic                     out_valid;
    logic signed [DATA_W-1:0] out_data;

    if (i == 0) begin : g_anchor
      // the anchor sees the new item as its inner neighbor
      assign in_valid = 1'b1;
      assign in_data  = push_value;
    end else begin : g_inner
      assign in_valid = valid_w[i-1];
      assign in_data  = data_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign out_valid = 1'b0;
      assign out_data  = '0;
    end else begin : g_outer
      assign out_valid = valid_w[i+1];
      assign out_data  = data_w[i+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .push_value  (push_value),
      .inner_valid (in_valid),
      .inner_data  (in_data),
      .outer_valid (out_valid),
      .outer_data  (out_data),
      .valid_q     (valid_w[i]),
      .data_q      (data_w[i])
    );
  end

  assign anchor_data = data_w[0];

endmodule

@@ src/double_ended_queue_core.sv @@
// Double-ended queue: two mirrored cell rows, one anchored at the front, one at the back.
// The accepting edge updates the cells, the count and the s1 status registers; the result
// register and out_valid are then loaded from them (cells update, then result latch).
// Throughput: one item per cycle; every cell updates from its neighbors at the accepting edge,
// so busy stays low and a new item may be started in every cycle.
// Reset: synchronous, active low; clears cell and pipeline valid bits and the count, not values.
module double_ended_queue_core import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  deq_req_t in_req,
  output logic     out_valid,
  output deq_rsp_t out_rsp
);

  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic accept;

  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] cnt_nxt;
  logic               full;
  logic               empty;

  cell_op_t op_front;
  cell_op_t op_back;
  cell_op_t row_op_front;
  cell_op_t row_op_back;

  logic signed [DATA_W-1:0] front_data;
  logic signed [DATA_W-1:0] back_data;

  logic [STATUS_W-1:0]      status_nxt;
  logic signed [DATA_W-1:0] popped_nxt;

  logic                     s1_valid_r;
  logic [STATUS_W-1:0]      s1_status_r;
  logic signed [DATA_W-1:0] s1_popped_r;

  logic     out_valid_r;
  deq_rsp_t out_rsp_r;
  deq_rsp_t out_rsp_nxt;
  logic [31:0] cnt_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (cnt_r == COUNT_W'(DEPTH));
  assign empty  = (cnt_r == '0);

  always_comb begin
    op_front   = CELL_HOLD;
    op_back    = CELL_HOLD;
    status_nxt = ST_OK;
    popped_nxt = '0;
    cnt_nxt    = cnt_r;
    unique case (in_req.req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_OVER;
        end else begin
          op_front = CELL_PUSH_ANCHOR;
          op_back  = CELL_PUSH_OPEN;
          cnt_nxt  = cnt_r + COUNT_W'(1);
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_OVER;
        end else begin
          op_front = CELL_PUSH_OPEN;
          op_back  = CELL_PUSH_ANCHOR;
          cnt_nxt  = cnt_r + COUNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_UNDER;
        end else begin
          op_front   = CELL_POP_ANCHOR;
          op_back    = CELL_POP_OPEN;
          popped_nxt = front_data;
          cnt_nxt    = cnt_r - COUNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_UNDER;
        end else begin
          op_front   = CELL_POP_OPEN;
          op_back    = CELL_POP_ANCHOR;
          popped_nxt = back_data;
          cnt_nxt    = cnt_r - COUNT_W'(1);
        end
      end
      default: begin
        // peek and unused codes change nothing
        status_nxt = ST_OK;
      end
    endcase
  end

  assign row_op_front = accept ? op_front : CELL_HOLD;
  assign row_op_back  = accept ? op_back  : CELL_HOLD;

  deq_row #(.DEPTH(DEPTH)) u_front_row (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (row_op_front),
    .push_value  (in_req.push_value),
    .anchor_data (front_data)
  );

  deq_row #(.DEPTH(DEPTH)) u_back_row (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (row_op_back),
    .push_value  (in_req.push_value),
    .anchor_data (back_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status_nxt;
      s1_popped_r <= popped_nxt;
    end
  end

  // cells and count already hold the state after the item; sample them here
  assign cnt_ext = 32'(cnt_r);

  always_comb begin
    out_rsp_nxt.status       = s1_status_r;
    out_rsp_nxt.popped_value = s1_popped_r;
    out_rsp_nxt.front_value  = empty ? '0 : front_data;
    out_rsp_nxt.back_value   = empty ? '0 : back_data;
    out_rsp_nxt.item_count   = cnt_ext[ITEM_COUNT_W-1:0];
    out_rsp_nxt.is_empty     = empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

@@ dv/tb_double_ended_queue_core.sv @@
// Self-checking testbench for the double-ended queue core: random and directed requests.
`timescale 1ns / 1ps

module tb_double_ended_queue_core;
  import deq_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  deq_req_t in_req = '0;
  logic     out_valid;
  deq_rsp_t out_rsp;

  deq_req_t pending_q[$];
  deq_rsp_t expected_rsp_q[$];

  int idle_pct = 38;
  int queued_count = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;
  logic took_item = 1'b0;

  // Shadow copy of the deque contents
  logic signed [DATA_W-1:0] shadow_slots [DEPTH];
  int head_slot = 0;
  int tail_slot = 0;
  int fill_level = 0;

  double_ended_queue_core #(.DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int wrap_next(int idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic int wrap_prev(int idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  // Apply one request to the shadow deque and return the response it should produce.
  function automatic deq_rsp_t apply_request(deq_req_t req);
    deq_rsp_t rsp;
    rsp = '0;
    rsp.status = ST_OK;
    case (req.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          rsp.status = ST_OVER;
        end else if (req.req_type == REQ_PUSH_FRONT) begin
          head_slot = wrap_prev(head_slot);
          shadow_slots[head_slot] = req.push_value;
          fill_level++;
        end else begin
          shadow_slots[tail_slot] = req.push_value;
          tail_slot = wrap_next(tail_slot);
          fill_level++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (fill_level == 0) begin
          rsp.status = ST_UNDER;
        end else if (req.req_type == REQ_POP_FRONT) begin
          rsp.popped_value = shadow_slots[head_slot];
          head_slot = wrap_next(head_slot);
          fill_level--;
        end else begin
          tail_slot = wrap_prev(tail_slot);
          rsp.popped_value = shadow_slots[tail_slot];
          fill_level--;
        end
      end
      default: ;  // peek and unused codes change nothing
    endcase
    if (fill_level != 0) begin
      rsp.front_value = shadow_slots[head_slot];
      rsp.back_value  = shadow_slots[wrap_prev(tail_slot)];
    end
    rsp.item_count = ITEM_COUNT_W'(fill_level);
    rsp.is_empty   = (fill_level == 0);
    return rsp;
  endfunction

  function automatic void check_field(string field, logic [DATA_W-1:0] exp_v,
                                      logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    end
  endfunction

  // Accept, predict and check
  always @(posedge clk) begin
    deq_rsp_t exp_rsp;
    took_item <= rst_n && start && !busy;
    if (rst_n) begin
      if (start && !busy) begin
        expected_rsp_q.insert(expected_rsp_q.size(), apply_request(in_req));
        accepted_count++;
      end
      if (out_valid) begin
        if (expected_rsp_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected response, expected none, actual %0h", $time, out_rsp);
        end else begin
          exp_rsp = expected_rsp_q[0];
          expected_rsp_q.delete(0);
          check_field("status", DATA_W'(exp_rsp.status), DATA_W'(out_rsp.status));
          check_field("popped_value", exp_rsp.popped_value, out_rsp.popped_value);
          check_field("front_value", exp_rsp.front_value, out_rsp.front_value);
          check_field("back_value", exp_rsp.back_value, out_rsp.back_value);
          check_field("item_count", DATA_W'(exp_rsp.item_count), DATA_W'(out_rsp.item_count));
          check_field("is_empty", DATA_W'(exp_rsp.is_empty), DATA_W'(out_rsp.is_empty));
        end
      end
    end
  end

  // Watchdog: fail when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Request driver: hold an item until it is taken, idle at random between items
  always @(negedge clk) begin
    deq_req_t noise;
    if (!rst_n) begin
      start  <= 1'b0;
      in_req <= '0;
    end else if (!start || took_item) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start  <= 1'b1;
        in_req <= pending_q[0];
        pending_q.delete(0);
      end else begin
        noise.req_type   = REQ_W'($urandom);
        noise.push_value = $urandom;
        start  <= 1'b0;
        in_req <= noise;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic [REQ_W-1:0] code, logic [DATA_W-1:0] value);
    deq_req_t req;
    req.req_type   = code;
    req.push_value = value;
    pending_q.insert(pending_q.size(), req);
    queued_count++;
  endtask

  // Mostly fill and drain bursts, so full and empty are hit often; the rest is a mix
  task automatic add_random_items(int n_items);
    int added;
    int burst_len;
    int pick;
    logic [REQ_W-1:0] code;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(9);
      burst_len = (pick < 6) ? $urandom_range(20, 17) : $urandom_range(30, 10);
      for (int i = 0; i < burst_len; i++) begin
        if (pick < 3) begin
          code = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        end else if (pick < 6) begin
          code = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        end else begin
          code = REQ_W'($urandom_range(15));
          if (code >= REQ_W'(4) && $urandom_range(3) != 0) code = code & 3'd3;
        end
        add_item(code, pick_value());
      end
      added += burst_len;
    end
  endtask

  task automatic drain_wait();
    while (accepted_count != queued_count || expected_rsp_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    foreach (shadow_slots[i]) shadow_slots[i] = '0;

    // Directed: empty-deque cases, value extremes, every code
    add_item(REQ_PEEK, '1);
    add_item(REQ_POP_FRONT, '1);
    add_item(REQ_POP_BACK, '1);
    add_item(REQ_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
    add_item(REQ_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}});
    add_item(REQ_PEEK, '0);
    add_item(REQ_W'(5), '0);
    add_item(REQ_W'(6), '1);
    add_item(REQ_W'(7), 32'h5a5a_a5a5);
    add_item(REQ_PUSH_FRONT, '1);
    add_item(REQ_PUSH_BACK, '0);
    add_item(REQ_POP_BACK, '0);
    add_item(REQ_POP_FRONT, '0);
    add_item(REQ_POP_BACK, '0);
    add_item(REQ_POP_FRONT, '0);
    add_item(REQ_POP_FRONT, '0);
    add_random_items(470);

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    drain_wait();
    idle_pct = 51;
    add_random_items(480);

    drain_wait();
    idle_pct = 0;
    add_random_items(480);

    drain_wait();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
